FILE: rtl/core/mcpdb_pkg.sv
// shared types, defaults and codes for the priority deque bank
package mcpdb_pkg;

	localparam int NUM_QUEUES_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int ID_WIDTH_DEF    = 16;

	localparam int QUEUE_ID_W = 5;
	localparam int ENTRY_ID_W = 16;
	localparam int RESULT_W   = 3;
	localparam int COUNT_W    = 4;

	typedef enum logic [RESULT_W-1:0] {
		RC_ADDED  = 3'd0,
		RC_FULL   = 3'd1,
		RC_SERVED = 3'd2,
		RC_EMPTY  = 3'd3,
		RC_BAD    = 3'd4
	} result_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FETCH
	} state_t;

	typedef struct packed {
		logic                  req_type;
		logic [QUEUE_ID_W-1:0] queue_id;
		logic [ENTRY_ID_W-1:0] entry_id;
		logic                  urgent;
	} req_t;

	typedef struct packed {
		result_code_t          result_code;
		logic [ENTRY_ID_W-1:0] served_id;
		logic                  served_urgent;
		logic [COUNT_W-1:0]    queue_count;
	} rsp_t;

endpackage

FILE: rtl/core/mcpdb_ram.sv
// generic single-write, single-read ram with registered read data
module mcpdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/multi_class_priority_deque_bank.sv
// top level: request sequencer, queue state ram and entry ram
//
// a bank of bounded queues, one per class, each kept as a circular buffer
// in a shared entry ram. the request channel (req_valid/req_ready, req)
// carries add or take requests; the response channel (rsp_valid/rsp_ready,
// rsp) returns exactly one response per request, in order.
// an add goes to the tail, or to the head when urgent; a take pops the head.
// an add, a rejected request or a bad class shows its response once the
// queue state is read, a served take after the queue state read and then the
// entry read, when the output register is free.
// one request is in flight at a time: the next is taken only once the
// read-modify-write of the queue state ram is done, followed, for a take,
// by the entry ram read.
// a new request is taken while an earlier response still waits in the
// output register; if the receiver stalls, the sequencer holds the finished
// request, and for an add its ram writes, until the output register frees up.
// reset clears the per-queue valid bits so every queue starts empty; no
// clearing pass is needed and requests are accepted right after reset.
module multi_class_priority_deque_bank #(
	parameter int NUM_QUEUES  = mcpdb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mcpdb_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = mcpdb_pkg::ID_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mcpdb_pkg::req_t     req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mcpdb_pkg::rsp_t     rsp
);

	import mcpdb_pkg::*;

	localparam int QIDX_W     = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
	localparam int SLOT_W     = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W      = SLOT_W + 1;
	localparam int META_W     = LEN_W + SLOT_W;
	localparam int STORE_SIZE = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W     = STORE_SIZE > 1 ? $clog2(STORE_SIZE) : 1;
	localparam int SID_W      = ID_WIDTH < ENTRY_ID_W ? ID_WIDTH : ENTRY_ID_W;
	localparam int DATA_W     = SID_W + 1;

	state_t state_q, state_d;

	req_t                   req_q;
	logic [NUM_QUEUES-1:0]  meta_vld_q;
	logic [LEN_W-1:0]       count_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic [QIDX_W-1:0] rd_qidx;
	logic [QIDX_W-1:0] qidx;
	logic              q_ok;
	logic              is_take;

	logic [META_W-1:0] meta_rdata;
	logic [DATA_W-1:0] data_rdata;
	logic [LEN_W-1:0]  cur_len;
	logic [SLOT_W-1:0] cur_head;
	logic [SLOT_W-1:0] prev_head;
	logic [SLOT_W-1:0] next_head;
	logic [SUM_W-1:0]  tail_sum;
	logic [SLOT_W-1:0] tail_slot;
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] new_head;
	logic [LEN_W-1:0]  new_len;
	logic [LEN_W-1:0]  after_len;
	logic              is_full;
	logic              is_empty;
	logic              add_ok;
	logic              take_ok;
	logic [ADDR_W-1:0] base_addr;
	logic [ADDR_W-1:0] entry_addr;
	logic              out_free;

	logic meta_re;
	logic meta_we;
	logic data_we;
	logic data_re;
	logic rsp_load;
	rsp_t rsp_d;

	assign rd_qidx = QIDX_W'(req.queue_id);
	assign qidx    = QIDX_W'(req_q.queue_id);
	assign q_ok    = 32'(req_q.queue_id) < NUM_QUEUES;
	assign is_take = req_q.req_type;

	// a queue never written since reset reads as empty with head at slot zero
	always_comb begin
		cur_len  = '0;
		cur_head = '0;
		if (q_ok && meta_vld_q[qidx]) begin
			cur_len  = meta_rdata[META_W-1:SLOT_W];
			cur_head = meta_rdata[SLOT_W-1:0];
		end
	end

	assign is_full  = cur_len == LEN_W'(QUEUE_DEPTH);
	assign is_empty = cur_len == '0;
	assign add_ok   = q_ok && !is_take && !is_full;
	assign take_ok  = q_ok && is_take && !is_empty;

	assign prev_head = (cur_head == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
	assign next_head = (cur_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

	// tail = head + len wrapped once around the ring
	assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_len);
	assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH))
		? SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);

	assign wr_slot = req_q.urgent ? prev_head : tail_slot;

	always_comb begin
		new_head = cur_head;
		new_len  = cur_len;
		if (add_ok) begin
			new_len = cur_len + 1'b1;
			if (req_q.urgent) begin
				new_head = prev_head;
			end
		end else if (take_ok) begin
			new_len  = cur_len - 1'b1;
			new_head = next_head;
		end
	end

	assign after_len = q_ok ? new_len : '0;

	assign base_addr  = ADDR_W'(qidx) * ADDR_W'(QUEUE_DEPTH);
	assign entry_addr = base_addr + ADDR_W'(take_ok ? cur_head : wr_slot);

	assign out_free = !rsp_valid_q || rsp_ready;

	mcpdb_ram #(
		.WIDTH (META_W),
		.DEPTH (NUM_QUEUES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (qidx),
		.wdata ({new_len, new_head}),
		.re    (meta_re),
		.raddr (rd_qidx),
		.rdata (meta_rdata)
	);

	mcpdb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_SIZE)
	) u_entry_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (entry_addr),
		.wdata ({req_q.urgent, req_q.entry_id[SID_W-1:0]}),
		.re    (data_re),
		.raddr (entry_addr),
		.rdata (data_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (take_ok) begin
					state_d = ST_FETCH;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FETCH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs per state
	always_comb begin
		req_ready = 1'b0;
		meta_re   = 1'b0;
		meta_we   = 1'b0;
		data_we   = 1'b0;
		data_re   = 1'b0;
		rsp_load  = 1'b0;
		rsp_d.result_code   = RC_BAD;
		rsp_d.served_id     = '0;
		rsp_d.served_urgent = 1'b0;
		rsp_d.queue_count   = COUNT_W'(after_len);
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				meta_re   = req_valid;
			end
			ST_LOOKUP: begin
				if (take_ok) begin
					meta_we = 1'b1;
					data_re = 1'b1;
				end else if (out_free) begin
					rsp_load = 1'b1;
					meta_we  = add_ok;
					data_we  = add_ok;
				end
				if (!q_ok) begin
					rsp_d.result_code = RC_BAD;
				end else if (is_take) begin
					rsp_d.result_code = RC_EMPTY;
				end else if (is_full) begin
					rsp_d.result_code = RC_FULL;
				end else begin
					rsp_d.result_code = RC_ADDED;
				end
			end
			ST_FETCH: begin
				rsp_load            = out_free;
				rsp_d.result_code   = RC_SERVED;
				rsp_d.served_id     = ENTRY_ID_W'(data_rdata[SID_W-1:0]);
				rsp_d.served_urgent = data_rdata[DATA_W-1];
				rsp_d.queue_count   = COUNT_W'(count_q);
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			meta_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (meta_we) begin
				meta_vld_q[qidx] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ST_LOOKUP) begin
			count_q <= after_len;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: bench/tb_top.sv
// self-checking testbench for the priority deque bank: random traffic, stalls, in-order checks
module tb_top;
	import mcpdb_pkg::*;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TAKE = 1'b1;

	localparam int RANDOM_REQS = 1300;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN       = 8;
	localparam int LIMIT       = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// queue contents as the block should hold them
	logic [ENTRY_ID_W-1:0] held_ids [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
	bit held_urgent [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
	int unsigned fill_level [NUM_QUEUES_DEF];
	int unsigned head_at [NUM_QUEUES_DEF];

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];

	int n_total = 0;
	int n_sent = 0;
	int n_rsp = 0;
	int n_errors = 0;
	int n_urgent_adds = 0;
	int code_seen [5];
	int cycle_count = 0;
	int send_wait = 0;
	int recv_wait = 0;
	int hold_left = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	multi_class_priority_deque_bank i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int unsigned q;
		int unsigned slot;
		o = '0;
		q = r.queue_id;
		if (q >= NUM_QUEUES_DEF) begin
			o.result_code = RC_BAD;
		end else begin
			if (r.req_type == REQ_ADD) begin
				if (fill_level[q] >= QUEUE_DEPTH_DEF) begin
					o.result_code = RC_FULL;
				end else begin
					// urgent entries go in front of the current head
					if (r.urgent) begin
						head_at[q] = (head_at[q] == 0) ? QUEUE_DEPTH_DEF - 1 : head_at[q] - 1;
						slot = head_at[q];
						n_urgent_adds++;
					end else begin
						slot = (head_at[q] + fill_level[q]) % QUEUE_DEPTH_DEF;
					end
					held_ids[q][slot] = r.entry_id;
					held_urgent[q][slot] = r.urgent;
					fill_level[q]++;
					o.result_code = RC_ADDED;
				end
			end else if (fill_level[q] == 0) begin
				o.result_code = RC_EMPTY;
			end else begin
				o.served_id = held_ids[q][head_at[q]];
				o.served_urgent = held_urgent[q][head_at[q]];
				head_at[q] = (head_at[q] + 1) % QUEUE_DEPTH_DEF;
				fill_level[q]--;
				o.result_code = RC_SERVED;
			end
			o.queue_count = COUNT_W'(fill_level[q]);
		end
		return o;
	endfunction

	// stretches of zero gaps alternate with random ones
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(5);
	endfunction

	task automatic push_request(logic kind, int q, logic [ENTRY_ID_W-1:0] id, logic urg);
		req_t r;
		r.req_type = kind;
		r.queue_id = QUEUE_ID_W'(q);
		r.entry_id = id;
		r.urgent = urg;
		pending_reqs.push_back(r);
	endtask

	task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	task automatic add_random_traffic(int count);
		int add_pct;
		logic [QUEUE_ID_W-1:0] hot [4];
		req_t r;
		add_pct = 50;
		for (int i = 0; i < count; i++) begin
			// every hundred requests pick a new fill/drain bias and a new set of busy classes
			if (i % 100 == 0) begin
				case ($urandom_range(2))
					0: add_pct = 25;
					1: add_pct = 55;
					default: add_pct = 80;
				endcase
				for (int k = 0; k < 4; k++)
					hot[k] = QUEUE_ID_W'($urandom_range(NUM_QUEUES_DEF - 1));
			end
			r.req_type = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_TAKE;
			r.queue_id = ($urandom_range(9) < 7) ? hot[$urandom_range(3)]
				: QUEUE_ID_W'($urandom_range(31));
			r.entry_id = ENTRY_ID_W'($urandom);
			r.urgent = ($urandom_range(2) == 0);
			pending_reqs.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic valid_n;
		req_t req_n;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_wait = 0;
		end else begin
			valid_n = req_valid;
			req_n = req;
			if (req_valid && req_ready) begin
				expected_rsps.push_back(serve_request(req));
				n_sent++;
				valid_n = 1'b0;
				send_wait = draw_gap(send_calm);
			end
			if (!valid_n && pending_reqs.size() != 0) begin
				if (send_wait > 0) begin
					send_wait--;
				end else begin
					valid_n = 1'b1;
					req_n = pending_reqs.pop_front();
				end
			end
			req_valid <= valid_n;
			req <= req_n;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_responses
		rsp_t want;
		logic ready_n;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (expected_rsps.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected response, expected none, got %0h", $time, rsp);
				end else begin
					want = expected_rsps.pop_front();
					code_seen[want.result_code]++;
					report_field("result_code", want.result_code, rsp.result_code);
					report_field("served_id", want.served_id, rsp.served_id);
					report_field("served_urgent", want.served_urgent, rsp.served_urgent);
					report_field("queue_count", want.queue_count, rsp.queue_count);
				end
				recv_wait = draw_gap(recv_calm);
				// one long back-pressure window so the block fills and stalls requests
				if (n_rsp == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_n = 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				ready_n = 1'b0;
			end else begin
				ready_n = 1'b1;
			end
			rsp_ready <= ready_n;
		end
	end

	initial begin
		// empty take, then both ends of a queue with extreme ids
		push_request(REQ_TAKE, 0, 16'h1234, 1'b1);
		push_request(REQ_ADD, 31, 16'hffff, 1'b0);
		push_request(REQ_ADD, 31, 16'h0000, 1'b1);
		push_request(REQ_TAKE, 31, 16'hffff, 1'b0);
		push_request(REQ_TAKE, 31, 16'h0000, 1'b1);
		push_request(REQ_TAKE, 31, 16'h5a5a, 1'b0);
		// fill one class with mixed urgency, overflow it, then drain it
		for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
			push_request(REQ_ADD, 5, ENTRY_ID_W'(16'h0003 << (2 * i)), i[0]);
		push_request(REQ_ADD, 5, 16'hbeef, 1'b1);
		push_request(REQ_ADD, 5, 16'hcafe, 1'b0);
		for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
			push_request(REQ_TAKE, 5, ENTRY_ID_W'($urandom), 1'($urandom));
		add_random_traffic(RANDOM_REQS);
		n_total = pending_reqs.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while ((n_sent < n_total || expected_rsps.size() != 0) && cycle_count < LIMIT)
			@(posedge clk);
		if (cycle_count >= LIMIT) begin
			$display("%0t: timeout, %0d of %0d requests sent, %0d responses outstanding",
				$time, n_sent, n_total, expected_rsps.size());
			$display("*** FAILED ***");
		end else begin
			repeat (DRAIN) @(posedge clk);
			if (expected_rsps.size() != 0) begin
				n_errors++;
				$display("%0t: %0d responses never arrived", $time, expected_rsps.size());
			end
			$display("%0d requests over %0d cycles: %0d added (%0d urgent), %0d rejected full,",
				n_sent, cycle_count, code_seen[RC_ADDED], n_urgent_adds, code_seen[RC_FULL]);
			$display("%0d served, %0d empty takes, %0d mismatches",
				code_seen[RC_SERVED], code_seen[RC_EMPTY], n_errors);
			if (n_errors == 0) begin
				$display("*** PASSED ***");
			end else begin
				$display("*** FAILED ***");
			end
		end
		$finish;
	end

endmodule

FILE: multi_class_priority_deque_bank.f
rtl/core/mcpdb_pkg.sv
rtl/core/mcpdb_ram.sv
rtl/core/multi_class_priority_deque_bank.sv
bench/tb_top.sv
